// ----- rtl/tsi_pkg.sv -----
package tsi_pkg;

	// number of servo axes, one lane each
	localparam int Axes = 3;

	// per-lane control for one accepted item
	typedef struct packed {
		logic start;  // load target and begin the step division
		logic step;   // add the step to the position
		logic snap;   // move the position onto the target
	} lane_ctrl_t;

endpackage

// ----- rtl/tsi_cmd_if.sv -----
interface tsi_cmd_if #(
	parameter int POS_BITS   = 12,
	parameter int COUNT_BITS = 8
) ();
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [POS_BITS-1:0]   target_base;
	logic [POS_BITS-1:0]   target_shoulder;
	logic [POS_BITS-1:0]   target_elbow;
	logic [COUNT_BITS-1:0] step_count;

	modport source (
		output valid, command, target_base, target_shoulder, target_elbow, step_count,
		input  ready
	);
	modport sink (
		input  valid, command, target_base, target_shoulder, target_elbow, step_count,
		output ready
	);
endinterface

// ----- rtl/tsi_res_if.sv -----
interface tsi_res_if #(
	parameter int POS_BITS = 12
) ();
	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] pos_base;
	logic [POS_BITS-1:0] pos_shoulder;
	logic [POS_BITS-1:0] pos_elbow;
	logic                pwm_update;
	logic                move_done;
	logic                busy_res;
	logic                refused;

	modport source (
		output valid, pos_base, pos_shoulder, pos_elbow, pwm_update, move_done,
			busy_res, refused,
		input  ready
	);
	modport sink (
		input  valid, pos_base, pos_shoulder, pos_elbow, pwm_update, move_done,
			busy_res, refused,
		output ready
	);
endinterface

// ----- rtl/tsi_axis_lane.sv -----
module tsi_axis_lane #(
	parameter int POS_BITS      = 12,
	parameter int FRAC_BITS     = 16,
	parameter int COUNT_BITS    = 8,
	parameter int HOME_POSITION = 1500
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsi_pkg::lane_ctrl_t   ctrl,
	input  logic [POS_BITS-1:0]   tgt,
	input  logic [COUNT_BITS-1:0] count,
	output logic [POS_BITS-1:0]   pos_next,
	output logic                  div_busy
);
	localparam int QW = POS_BITS + FRAC_BITS;   // quotient magnitude width
	localparam int SW = QW + 1;                 // signed step width
	localparam int CW = $clog2(QW + 1);

	logic [POS_BITS-1:0]   pos_q;
	logic [POS_BITS-1:0]   tgt_q;
	logic signed [SW-1:0]  step_q;

	logic [COUNT_BITS-1:0] den_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [QW-1:0]         quo_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;

	// signed distance to the new target and its magnitude
	logic signed [POS_BITS:0] diff;
	logic [POS_BITS-1:0]      mag;
	always_comb begin
		diff = $signed({1'b0, tgt}) - $signed({1'b0, pos_q});
		mag  = diff[POS_BITS] ? POS_BITS'(-diff) : diff[POS_BITS-1:0];
	end

	// one restoring division step a cycle
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS-1:0] rem_nx;
	logic [QW-1:0]         quo_nx;
	logic [SW-1:0]         quo_ext;
	always_comb begin
		trial = {rem_q, quo_q[QW-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_nx = COUNT_BITS'(trial - {1'b0, den_q});
			quo_nx = {quo_q[QW-2:0], 1'b1};
		end else begin
			rem_nx = trial[COUNT_BITS-1:0];
			quo_nx = {quo_q[QW-2:0], 1'b0};
		end
		quo_ext = {1'b0, quo_nx};
	end

	assign div_busy = (cnt_q != '0);

	// position plus step, floored and clamped
	logic signed [SW:0]  sum;
	logic [POS_BITS-1:0] adv;
	always_comb begin
		sum = $signed({2'b00, pos_q, {FRAC_BITS{1'b0}}}) + $signed({step_q[SW-1], step_q});
		if (sum[SW])
			adv = '0;
		else if (sum[QW])
			adv = '1;
		else
			adv = sum[QW-1:FRAC_BITS];
	end

	// next position for this item
	always_comb begin
		if (ctrl.snap)
			pos_next = tgt_q;
		else if (ctrl.step)
			pos_next = adv;
		else
			pos_next = pos_q;
	end

	// position, target and step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_BITS'(HOME_POSITION);
			tgt_q  <= POS_BITS'(HOME_POSITION);
			step_q <= '0;
			cnt_q  <= '0;
		end else begin
			pos_q <= pos_next;
			if (ctrl.start) begin
				tgt_q <= tgt;
				if (count == '0) begin
					step_q <= '0;
				end else begin
					cnt_q <= CW'(QW);
				end
			end else if (div_busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					step_q <= neg_q ? $signed(-quo_ext) : $signed(quo_ext);
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			den_q <= count;
			rem_q <= '0;
			quo_q <= {mag, {FRAC_BITS{1'b0}}};
			neg_q <= diff[POS_BITS];
		end else if (div_busy) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

endmodule

// ----- rtl/three_axis_servo_interpolator_unit.sv -----
// channel  dir  handshake         payload
// cmd      in   valid/ready       command, target_base/shoulder/elbow, step_count
// res      out  valid/ready       pos_base/shoulder/elbow, pwm_update, move_done,
//                                 busy_res, refused
//
// every item gives one result, registered in the cycle after the item is taken
// a tick needs no division; an accepted start then runs the three lane dividers,
// one quotient bit a cycle, and cmd.ready stays low until all POS_BITS+FRAC_BITS
// quotient bits (28 at the defaults) are done; a zero count skips the division
// a stalled res holds its item and keeps cmd.ready low until it is taken
// reset puts every axis at HOME_POSITION with no move in progress
module three_axis_servo_interpolator_unit #(
	parameter int POS_BITS      = 12,
	parameter int FRAC_BITS     = 16,
	parameter int COUNT_BITS    = 8,
	parameter int HOME_POSITION = 1500
) (
	input  logic      clk,
	input  logic      arst_n,
	tsi_cmd_if.sink   cmd,
	tsi_res_if.source res
);
	logic [COUNT_BITS-1:0] ticks_done_q;
	logic [COUNT_BITS-1:0] ticks_total_q;
	logic                  moving_q;
	logic                  res_valid_q;

	logic [POS_BITS-1:0]     tgt      [tsi_pkg::Axes];
	logic [POS_BITS-1:0]     pos_next [tsi_pkg::Axes];
	logic [tsi_pkg::Axes-1:0] lane_busy;
	tsi_pkg::lane_ctrl_t     ctrl;

	logic accept;
	logic start_ok;
	logic refuse;
	logic tick;
	logic moving_next;

	// merge: any lane still dividing holds the input
	assign cmd.ready = !(|lane_busy) && (!res_valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;

	// decode of the accepted item
	always_comb begin
		start_ok  = accept && cmd.command && !moving_q;
		refuse    = accept && cmd.command && moving_q;
		tick      = accept && !cmd.command && moving_q;
		ctrl.start = start_ok;
		ctrl.step  = tick && (ticks_done_q < ticks_total_q);
		ctrl.snap  = tick && !(ticks_done_q < ticks_total_q);
		if (start_ok)
			moving_next = 1'b1;
		else if (ctrl.snap)
			moving_next = 1'b0;
		else
			moving_next = moving_q;
	end

	assign tgt[0] = cmd.target_base;
	assign tgt[1] = cmd.target_shoulder;
	assign tgt[2] = cmd.target_elbow;

	// one lane per axis
	for (genvar a = 0; a < tsi_pkg::Axes; a++) begin : g_lane
		tsi_axis_lane #(
			.POS_BITS      (POS_BITS),
			.FRAC_BITS     (FRAC_BITS),
			.COUNT_BITS    (COUNT_BITS),
			.HOME_POSITION (HOME_POSITION)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.tgt      (tgt[a]),
			.count    (cmd.step_count),
			.pos_next (pos_next[a]),
			.div_busy (lane_busy[a])
		);
	end

	// move sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_done_q  <= '0;
			ticks_total_q <= '0;
			moving_q      <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			moving_q <= moving_next;
			if (start_ok) begin
				ticks_done_q  <= '0;
				ticks_total_q <= cmd.step_count;
			end else if (ctrl.step) begin
				ticks_done_q <= ticks_done_q + 1'b1;
			end
			if (accept)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			res.pos_base     <= pos_next[0];
			res.pos_shoulder <= pos_next[1];
			res.pos_elbow    <= pos_next[2];
			res.pwm_update   <= tick;
			res.move_done    <= ctrl.snap;
			res.busy_res     <= moving_next;
			res.refused      <= refuse;
		end
	end

	assign res.valid = res_valid_q;

endmodule
